FILE: rtl/sfir_pkg.sv
// Package: sizes, item mode codes and shared types of the symmetric FIR filter.
`default_nettype none
package sfir_pkg;

	// Storage limits and data widths.
	localparam int MAX_DISTINCT = 16;
	localparam int SAMPLE_W     = 16;
	localparam int COEF_W       = 16;
	localparam int HIST_DEPTH   = 2 * MAX_DISTINCT - 1;

	// Address and count widths derived from the storage limits.
	localparam int HADDR_W = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
	localparam int CIDX_W  = (MAX_DISTINCT > 1) ? $clog2(MAX_DISTINCT) : 1;
	localparam int NCNT_W  = $clog2(MAX_DISTINCT + 1);

	// Datapath widths: pre-add, product and accumulator.
	localparam int PRE_W  = SAMPLE_W + 1;
	localparam int PROD_W = PRE_W + COEF_W;
	localparam int ACC_W  = PROD_W + CIDX_W + 1;

	// Fixed port widths.
	localparam int MODE_W = 2;
	localparam int IDX_W  = 4;
	localparam int TAPS_W = 5;

	// Item modes.
	localparam logic [MODE_W-1:0] MODE_FILTER = 2'd0;
	localparam logic [MODE_W-1:0] MODE_COEF   = 2'd1;
	localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd2;

	// Tag that travels down the multiply-accumulate pipeline with each tap read.
	typedef struct packed {
		logic valid;
		logic first;
		logic last;
		logic center;
	} step_t;

endpackage
`default_nettype wire

FILE: rtl/sfir_item_if.sv
// Interface: input item channel of the symmetric FIR filter.
`default_nettype none
interface sfir_item_if;
	logic                              valid;
	logic                              ready;
	logic [sfir_pkg::MODE_W-1:0]       mode;
	logic signed [sfir_pkg::SAMPLE_W-1:0] sample;
	logic [sfir_pkg::IDX_W-1:0]        coef_index;
	logic signed [sfir_pkg::COEF_W-1:0]   coef_value;

	modport source (output valid, output mode, output sample, output coef_index,
		output coef_value, input ready);
	modport sink (input valid, input mode, input sample, input coef_index,
		input coef_value, output ready);
endinterface
`default_nettype wire

FILE: rtl/sfir_result_if.sv
// Interface: result item channel of the symmetric FIR filter.
`default_nettype none
interface sfir_result_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [sfir_pkg::SAMPLE_W-1:0] filtered;
	logic                                 saturated;

	modport source (output valid, output filtered, output saturated, input ready);
	modport sink (input valid, input filtered, input saturated, output ready);
endinterface
`default_nettype wire

FILE: rtl/symmetric_fir_filter.sv
// Top level: folded type I symmetric FIR filter with its sequencer and memories.
//
// This block is an odd-length (2N-1 taps) symmetric FIR filter in folded form,
// with N set by the distinct_taps register (0 acts as 1, values above 16 act
// as 16). Each input item carries a mode: a filter item pushes its sample into
// a 31-entry circular history memory and yields one result item, a coefficient
// item writes one of the 16 distinct Q1.15 coefficients, and a clear item
// empties the history so that earlier samples read as zero again; the latter
// two yield no result. For every tap pair the sequencer reads two history
// entries and one coefficient from synchronous memories in one cycle, and a
// shared pipeline pre-adds the pair, multiplies and accumulates at full
// precision; the center tap takes the last step. The sum is shifted right by
// 15 with floor rounding and saturated to 16 bits, and the saturated flag
// marks a clipped result. A filter item holds the block from its accept, which
// writes the sample, through N read steps on the history and coefficient ports
// and the pipeline drain until its result enters the output register once an
// earlier result is taken. Coefficient and clear items complete on accept. The
// output register lets the next item in while a result still waits to be
// taken. Write distinct_taps only while no filter item is in progress.
`default_nettype none
module symmetric_fir_filter (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	sfir_item_if.sink                          item,
	sfir_result_if.source                      result,
	input  wire logic                          cfg_wr_en,
	input  wire logic [sfir_pkg::TAPS_W-1:0]   cfg_wr_data
);

	localparam int HADDR_W = sfir_pkg::HADDR_W;
	localparam int CIDX_W  = sfir_pkg::CIDX_W;
	localparam int NCNT_W  = sfir_pkg::NCNT_W;
	localparam logic [HADDR_W-1:0] HIST_LAST  = HADDR_W'(sfir_pkg::HIST_DEPTH - 1);
	localparam logic [HADDR_W:0]   HIST_DEPTH = (HADDR_W+1)'(sfir_pkg::HIST_DEPTH);

	// Sequencer states.
	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_ISSUE  = 2'd1;
	localparam logic [1:0] ST_DRAIN  = 2'd2;
	localparam logic [1:0] ST_FINISH = 2'd3;

	logic [1:0]                           state_q;
	logic [sfir_pkg::TAPS_W-1:0]          taps_q;
	logic [HADDR_W-1:0]                   write_pos_q;
	logic [HADDR_W-1:0]                   addr_a_q;
	logic [HADDR_W-1:0]                   addr_b_q;
	logic [CIDX_W-1:0]                    k_q;
	logic                                 out_valid_q;
	logic signed [sfir_pkg::SAMPLE_W-1:0] out_filtered_q;
	logic                                 out_saturated_q;

	logic [NCNT_W-1:0]                    n_eff;
	logic [HADDR_W:0]                     b_sum;
	logic [HADDR_W-1:0]                   b_start;
	logic                                 accept;
	logic                                 filter_acc;
	logic                                 coef_acc;
	logic                                 clear_acc;
	logic                                 k_last;
	logic                                 out_free;
	sfir_pkg::step_t                      step;
	logic signed [sfir_pkg::SAMPLE_W-1:0] hist_a;
	logic signed [sfir_pkg::SAMPLE_W-1:0] hist_b;
	logic signed [sfir_pkg::COEF_W-1:0]   coef;
	logic                                 acc_done;
	logic signed [sfir_pkg::SAMPLE_W-1:0] mac_filtered;
	logic                                 mac_saturated;

	// Effective number of distinct coefficients, clamped to the supported range.
	always_comb begin
		if (taps_q == '0) begin
			n_eff = NCNT_W'(1);
		end else if (int'(taps_q) > sfir_pkg::MAX_DISTINCT) begin
			n_eff = NCNT_W'(sfir_pkg::MAX_DISTINCT);
		end else begin
			n_eff = NCNT_W'(taps_q);
		end
	end

	// The far end of the window sits 2N-2 slots behind the new sample.
	assign b_sum   = {1'b0, write_pos_q} + HIST_DEPTH - (HADDR_W+1)'(2 * int'(n_eff) - 2);
	assign b_start = (b_sum >= HIST_DEPTH) ? HADDR_W'(b_sum - HIST_DEPTH) : HADDR_W'(b_sum);

	assign item.ready = (state_q == ST_IDLE);
	assign accept     = item.valid & item.ready;
	assign filter_acc = accept & (item.mode == sfir_pkg::MODE_FILTER);
	assign coef_acc   = accept & (item.mode == sfir_pkg::MODE_COEF)
		& (int'(item.coef_index) < sfir_pkg::MAX_DISTINCT);
	assign clear_acc  = accept & (item.mode == sfir_pkg::MODE_CLEAR);

	assign k_last   = (int'(k_q) + 1 == int'(n_eff));
	assign out_free = ~out_valid_q | result.ready;

	// One read step per distinct coefficient; the last step is the center tap.
	always_comb begin
		step.valid  = (state_q == ST_ISSUE);
		step.first  = (k_q == '0);
		step.last   = k_last;
		step.center = k_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			taps_q      <= sfir_pkg::TAPS_W'(1);
			write_pos_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				taps_q <= cfg_wr_data;
			end
			if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (filter_acc) begin
						write_pos_q <= (write_pos_q == HIST_LAST) ? '0 : write_pos_q + 1'b1;
						state_q     <= ST_ISSUE;
					end else if (clear_acc) begin
						write_pos_q <= '0;
					end
				end
				ST_ISSUE: begin
					if (k_last) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (acc_done) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Read addresses walk inward from both ends of the window.
	always_ff @(posedge clk) begin
		if (filter_acc) begin
			addr_a_q <= write_pos_q;
			addr_b_q <= b_start;
			k_q      <= '0;
		end else if (state_q == ST_ISSUE) begin
			addr_a_q <= (addr_a_q == '0) ? HIST_LAST : addr_a_q - 1'b1;
			addr_b_q <= (addr_b_q == HIST_LAST) ? '0 : addr_b_q + 1'b1;
			k_q      <= k_q + 1'b1;
		end
		if (state_q == ST_FINISH && out_free) begin
			out_filtered_q  <= mac_filtered;
			out_saturated_q <= mac_saturated;
		end
	end

	assign result.valid     = out_valid_q;
	assign result.filtered  = out_filtered_q;
	assign result.saturated = out_saturated_q;

	sfir_hist_mem u_hist (
		.clk       (clk),
		.arst_n    (arst_n),
		.clear     (clear_acc),
		.wr_en     (filter_acc),
		.wr_addr   (write_pos_q),
		.wr_data   (item.sample),
		.rd_addr_a (addr_a_q),
		.rd_addr_b (addr_b_q),
		.rd_data_a (hist_a),
		.rd_data_b (hist_b)
	);

	sfir_coef_mem u_coef (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (coef_acc),
		.wr_addr (CIDX_W'(item.coef_index)),
		.wr_data (item.coef_value),
		.rd_addr (k_q),
		.rd_data (coef)
	);

	sfir_mac u_mac (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.hist_a    (hist_a),
		.hist_b    (hist_b),
		.coef      (coef),
		.acc_done  (acc_done),
		.filtered  (mac_filtered),
		.saturated (mac_saturated)
	);

endmodule
`default_nettype wire

FILE: rtl/sfir_hist_mem.sv
// Sample history memory: one write port, two registered read ports, valid bits.
`default_nettype none
module sfir_hist_mem (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 clear,
	input  wire logic                                 wr_en,
	input  wire logic [sfir_pkg::HADDR_W-1:0]         wr_addr,
	input  wire logic signed [sfir_pkg::SAMPLE_W-1:0] wr_data,
	input  wire logic [sfir_pkg::HADDR_W-1:0]         rd_addr_a,
	input  wire logic [sfir_pkg::HADDR_W-1:0]         rd_addr_b,
	output logic signed [sfir_pkg::SAMPLE_W-1:0]      rd_data_a,
	output logic signed [sfir_pkg::SAMPLE_W-1:0]      rd_data_b
);

	logic signed [sfir_pkg::SAMPLE_W-1:0] mem [sfir_pkg::HIST_DEPTH];
	logic [sfir_pkg::HIST_DEPTH-1:0]      vld_q;
	logic signed [sfir_pkg::SAMPLE_W-1:0] data_a_q;
	logic signed [sfir_pkg::SAMPLE_W-1:0] data_b_q;
	logic                                 vld_a_q;
	logic                                 vld_b_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		data_a_q <= mem[rd_addr_a];
		data_b_q <= mem[rd_addr_b];
	end

	// A slot that was never written since the last clear reads as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q   <= '0;
			vld_a_q <= 1'b0;
			vld_b_q <= 1'b0;
		end else begin
			if (clear) begin
				vld_q <= '0;
			end else if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			vld_a_q <= vld_q[rd_addr_a];
			vld_b_q <= vld_q[rd_addr_b];
		end
	end

	assign rd_data_a = vld_a_q ? data_a_q : '0;
	assign rd_data_b = vld_b_q ? data_b_q : '0;

endmodule
`default_nettype wire

FILE: rtl/sfir_coef_mem.sv
// Coefficient memory: one write port, one registered read port, valid bits.
`default_nettype none
module sfir_coef_mem (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               wr_en,
	input  wire logic [sfir_pkg::CIDX_W-1:0]        wr_addr,
	input  wire logic signed [sfir_pkg::COEF_W-1:0] wr_data,
	input  wire logic [sfir_pkg::CIDX_W-1:0]        rd_addr,
	output logic signed [sfir_pkg::COEF_W-1:0]      rd_data
);

	logic signed [sfir_pkg::COEF_W-1:0] mem [sfir_pkg::MAX_DISTINCT];
	logic [sfir_pkg::MAX_DISTINCT-1:0]  vld_q;
	logic signed [sfir_pkg::COEF_W-1:0] data_q;
	logic                               rd_vld_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		data_q <= mem[rd_addr];
	end

	// Coefficients read as zero until written.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			rd_vld_q <= vld_q[rd_addr];
		end
	end

	assign rd_data = rd_vld_q ? data_q : '0;

endmodule
`default_nettype wire

FILE: rtl/sfir_mac.sv
// Pre-add, multiply and accumulate pipeline with the final shift and saturation.
`default_nettype none
module sfir_mac (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire sfir_pkg::step_t                      step,
	input  wire logic signed [sfir_pkg::SAMPLE_W-1:0] hist_a,
	input  wire logic signed [sfir_pkg::SAMPLE_W-1:0] hist_b,
	input  wire logic signed [sfir_pkg::COEF_W-1:0]   coef,
	output logic                                      acc_done,
	output logic signed [sfir_pkg::SAMPLE_W-1:0]      filtered,
	output logic                                      saturated
);

	localparam int ACC_W = sfir_pkg::ACC_W;
	localparam int SW    = sfir_pkg::SAMPLE_W;
	localparam logic signed [ACC_W-1:0] SAT_MAX =
		{{(ACC_W-SW+1){1'b0}}, {(SW-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] SAT_MIN = ~SAT_MAX;

	sfir_pkg::step_t                       step_s1;
	sfir_pkg::step_t                       step_s2;
	sfir_pkg::step_t                       step_s3;
	logic signed [sfir_pkg::PRE_W-1:0]     pre_s2;
	logic signed [sfir_pkg::COEF_W-1:0]    coef_s2;
	logic signed [sfir_pkg::PROD_W-1:0]    prod_s3;
	logic signed [ACC_W-1:0]               acc_q;
	logic                                  done_q;
	logic signed [sfir_pkg::PRE_W-1:0]     b_ext;
	logic signed [ACC_W-1:0]               shifted;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_s1 <= '0;
			step_s2 <= '0;
			step_s3 <= '0;
			done_q  <= 1'b0;
		end else begin
			step_s1 <= step;
			step_s2 <= step_s1;
			step_s3 <= step_s2;
			done_q  <= step_s3.valid & step_s3.last;
		end
	end

	// The center tap has no mirror partner, so its second operand is dropped.
	assign b_ext = step_s1.center ? '0 : sfir_pkg::PRE_W'(hist_b);

	always_ff @(posedge clk) begin
		pre_s2  <= sfir_pkg::PRE_W'(hist_a) + b_ext;
		coef_s2 <= coef;
		prod_s3 <= pre_s2 * coef_s2;
		if (step_s3.valid) begin
			acc_q <= (step_s3.first ? '0 : acc_q) + ACC_W'(prod_s3);
		end
	end

	assign acc_done = done_q;

	// Arithmetic shift floors toward minus infinity, then clip to the sample range.
	assign shifted = acc_q >>> (sfir_pkg::COEF_W - 1);

	always_comb begin
		if (shifted > SAT_MAX) begin
			filtered  = SW'(SAT_MAX);
			saturated = 1'b1;
		end else if (shifted < SAT_MIN) begin
			filtered  = SW'(SAT_MIN);
			saturated = 1'b1;
		end else begin
			filtered  = SW'(shifted);
			saturated = 1'b0;
		end
	end

endmodule
`default_nettype wire
